/* rtl/rrpl_pkg.sv */
`timescale 1ns / 1ps
package rrpl_pkg;

    localparam int FracBits  = 16;
    localparam int SineDepth = 256;
    localparam int SineIdxW  = $clog2(SineDepth);
    localparam int SineW     = 18;
    localparam int QuotW     = 66;

    localparam logic [1:0] KIND_TABLE = 2'd0;
    localparam logic [1:0] KIND_SHELF = 2'd1;

    localparam logic [2:0] REG_ORG_X = 3'd0;
    localparam logic [2:0] REG_ORG_Y = 3'd1;
    localparam logic [2:0] REG_ORG_Z = 3'd2;
    localparam logic [2:0] REG_DIR_X = 3'd3;
    localparam logic [2:0] REG_DIR_Y = 3'd4;
    localparam logic [2:0] REG_DIR_Z = 3'd5;
    localparam logic [2:0] REG_EPS   = 3'd6;

    // default sizes, round to nearest of n/d in Q16.16
    localparam logic signed [31:0] TABLE_W = 32'sd91750;
    localparam logic signed [31:0] TABLE_D = 32'sd58982;
    localparam logic signed [31:0] TABLE_H = 32'sd49152;
    localparam logic signed [31:0] SHELF_W = 32'sd65536;
    localparam logic signed [31:0] SHELF_H = 32'sd117965;
    localparam logic signed [31:0] SHELF_D = 32'sd19661;

    typedef struct packed {
        logic [1:0]         kind;
        logic [1:0]         param_count;
        logic signed [31:0] param_first;
        logic signed [31:0] param_second;
        logic signed [31:0] param_third;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic [15:0]        yaw_angle;
    } in_beat_t;

    typedef struct packed {
        logic               hit;
        logic signed [31:0] local_x;
        logic signed [31:0] local_y;
        logic signed [31:0] local_z;
    } out_beat_t;

    // quarter-wave sine, Q30, truncating Taylor series up to x^13
    function automatic logic [63:0] quarter_sine(input logic [31:0] u);
        logic [63:0] x;
        logic [63:0] term;
        logic signed [63:0] sum;
        x    = (64'(u) * 64'd3373259426) >> 15;
        term = x;
        sum  = $signed(x);
        for (int n = 1; n <= 6; n++) begin
            term = (((term * x) >> 30) * x) >> 30;
            term = term / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) sum = sum - $signed(term);
            else            sum = sum + $signed(term);
        end
        if (sum < 0) sum = 0;
        if (sum > (64'sd1 <<< 30)) sum = 64'sd1 <<< 30;
        return sum;
    endfunction

    function automatic logic signed [17:0] sine_entry(input logic [SineIdxW-1:0] idx);
        logic [15:0] phase;
        logic [1:0]  q;
        logic [13:0] r;
        logic [31:0] u;
        logic [63:0] mag;
        phase = 16'((64'(idx) * 64'd65536) / 64'(SineDepth));
        q     = phase[15:14];
        r     = phase[13:0];
        u     = q[0] ? (32'd16384 - 32'(r)) : 32'(r);
        mag   = (quarter_sine(u) + (64'd1 << (29 - FracBits))) >> (30 - FracBits);
        return q[1] ? -$signed(18'(mag)) : $signed(18'(mag));
    endfunction

    // whole table built at elaboration, packed entry i at bits [i*SineW +: SineW]
    function automatic logic [SineDepth*SineW-1:0] sine_rom();
        logic [SineDepth*SineW-1:0] rom;
        rom = '0;
        for (int i = 0; i < SineDepth; i++) begin
            rom[i*SineW +: SineW] = sine_entry(SineIdxW'(i));
        end
        return rom;
    endfunction

    localparam logic [SineDepth*SineW-1:0] SINE_ROM = sine_rom();

    function automatic logic signed [17:0] sine_lookup(input logic [SineIdxW-1:0] idx);
        return $signed(SINE_ROM[32'(idx) * SineW +: SineW]);
    endfunction

endpackage

/* rtl/rrpl_div.sv */
`timescale 1ns / 1ps
// Pipelined restoring divider: one quotient bit per stage, stall-aware.
// Signed truncating quotient of num / den, den nonzero when used.
module rrpl_div (
    input  logic                                clk,
    input  logic                                advance,
    input  logic signed [rrpl_pkg::QuotW-1:0]   num,
    input  logic signed [34:0]                  den,
    output logic signed [rrpl_pkg::QuotW-1:0]   quot
);
    localparam int N = rrpl_pkg::QuotW;

    logic [N-1:0]  rem_reg  [N+1];
    logic [N-1:0]  q_reg    [N+1];
    logic [34:0]   d_reg    [N+1];
    logic          neg_reg  [N+1];
    logic [N:0]    trial    [N];

    always_comb
    begin
        for (int i = 0; i < N; i++) begin
            trial[i] = {rem_reg[i], q_reg[i][N-1]} - (N+1)'(d_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance) begin
            rem_reg[0] <= '0;
            q_reg[0]   <= num[N-1] ? N'(-num) : N'(num);
            d_reg[0]   <= den[34] ? 35'(-den) : 35'(den);
            neg_reg[0] <= num[N-1] ^ den[34];
            for (int i = 0; i < N; i++) begin
                neg_reg[i+1] <= neg_reg[i];
                d_reg[i+1]   <= d_reg[i];
                if (!trial[i][N]) begin
                    rem_reg[i+1] <= trial[i][N-1:0];
                    q_reg[i+1]   <= {q_reg[i][N-2:0], 1'b1};
                end else begin
                    rem_reg[i+1] <= {rem_reg[i][N-2:0], q_reg[i][N-1]};
                    q_reg[i+1]   <= {q_reg[i][N-2:0], 1'b0};
                end
            end
        end
    end

    assign quot = neg_reg[N] ? -$signed(q_reg[N]) : $signed(q_reg[N]);
endmodule

/* rtl/ray_rect_pick_local.sv */
`timescale 1ns / 1ps
// Pipeline from input beat to result beat: 4 front stages, 67 divider stages and 2 back stages (s4, result).
// Throughput: one beat per cycle; the whole pipe advances together and halts when
// the output register is full and not taken.
// The divider is a load stage plus a 66-stage bit-per-stage array and sets the latency.
// Reset clears valid bits and config registers (epsilon resets to 1); payload is not reset.
module ray_rect_pick_local (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  rrpl_pkg::in_beat_t    in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output rrpl_pkg::out_beat_t   out_data,
    input  logic                  cfg_we,
    input  logic [2:0]            cfg_index,
    input  logic [31:0]           cfg_data
);
    localparam int N    = rrpl_pkg::QuotW;
    localparam int Pipe = N + 7;

    // config
    logic signed [31:0] org_x_reg, org_y_reg, org_z_reg;
    logic signed [31:0] dir_x_reg, dir_y_reg, dir_z_reg;
    logic [16:0]        eps_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            org_x_reg <= '0; org_y_reg <= '0; org_z_reg <= '0;
            dir_x_reg <= '0; dir_y_reg <= '0; dir_z_reg <= '0;
            eps_reg   <= 17'd1;
        end else if (cfg_we) begin
            case (cfg_index)
                rrpl_pkg::REG_ORG_X: org_x_reg <= cfg_data;
                rrpl_pkg::REG_ORG_Y: org_y_reg <= cfg_data;
                rrpl_pkg::REG_ORG_Z: org_z_reg <= cfg_data;
                rrpl_pkg::REG_DIR_X: dir_x_reg <= cfg_data;
                rrpl_pkg::REG_DIR_Y: dir_y_reg <= cfg_data;
                rrpl_pkg::REG_DIR_Z: dir_z_reg <= cfg_data;
                rrpl_pkg::REG_EPS:   eps_reg   <= cfg_data[16:0];
                default: ;
            endcase
        end
    end

    // global stall: whole pipe moves when output slot is free
    logic advance;
    assign advance  = !out_valid || out_ready;
    assign in_ready = advance;

    logic [Pipe-1:0] vld_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) vld_reg <= '0;
        else if (advance) vld_reg <= {vld_reg[Pipe-2:0], in_valid};
    end

    // item sideband carried along the pipe
    typedef struct packed {
        logic               ok;      // known kind and passes parallel test
        logic               shelf;
        logic signed [31:0] w;
        logic signed [31:0] hd;      // table d / shelf h
        logic signed [31:0] lox, loy, loz;
        logic signed [31:0] dx, dy, dz;
    } side_t;

    // s0: sine lookup, subtract, size defaults
    logic signed [17:0] s0_s_reg, s0_c_reg;
    logic signed [32:0] s0_vx_reg, s0_vy_reg, s0_vz_reg;
    logic [1:0]         s0_kind_reg;
    logic signed [31:0] s0_w_reg, s0_p2_reg, s0_p3_reg;
    logic [15:0]        cos_ang;
    assign cos_ang = in_data.yaw_angle + 16'd16384;

    always_ff @(posedge clk)
    begin
        if (advance) begin
            s0_s_reg  <= rrpl_pkg::sine_lookup(in_data.yaw_angle[15 -: rrpl_pkg::SineIdxW]);
            s0_c_reg  <= rrpl_pkg::sine_lookup(cos_ang[15 -: rrpl_pkg::SineIdxW]);
            s0_vx_reg <= 33'(org_x_reg) - 33'(in_data.pos_x);
            s0_vy_reg <= 33'(org_y_reg) - 33'(in_data.pos_y);
            s0_vz_reg <= 33'(org_z_reg) - 33'(in_data.pos_z);
            s0_kind_reg <= in_data.kind;
            if (in_data.kind == rrpl_pkg::KIND_TABLE) begin
                s0_w_reg  <= (in_data.param_count > 2'd0) ? in_data.param_first  : rrpl_pkg::TABLE_W;
                s0_p2_reg <= (in_data.param_count > 2'd1) ? in_data.param_second : rrpl_pkg::TABLE_D;
                s0_p3_reg <= (in_data.param_count > 2'd2) ? in_data.param_third  : rrpl_pkg::TABLE_H;
            end else begin
                s0_w_reg  <= (in_data.param_count > 2'd0) ? in_data.param_first  : rrpl_pkg::SHELF_W;
                s0_p2_reg <= (in_data.param_count > 2'd1) ? in_data.param_second : rrpl_pkg::SHELF_H;
                s0_p3_reg <= (in_data.param_count > 2'd2) ? in_data.param_third  : rrpl_pkg::SHELF_D;
            end
        end
    end

    // s1: eight products
    logic signed [51:0] s1_vxc_reg, s1_vzs_reg, s1_vxs_reg, s1_vzc_reg;
    logic signed [50:0] s1_rxc_reg, s1_rzs_reg, s1_rxs_reg, s1_rzc_reg;
    logic signed [32:0] s1_vy_reg;
    logic [1:0]         s1_kind_reg;
    logic signed [31:0] s1_w_reg, s1_p2_reg, s1_p3_reg;

    always_ff @(posedge clk)
    begin
        if (advance) begin
            s1_vxc_reg <= 52'(s0_vx_reg) * 52'(s0_c_reg);
            s1_vzs_reg <= 52'(s0_vz_reg) * 52'(s0_s_reg);
            s1_vxs_reg <= 52'(s0_vx_reg) * 52'(s0_s_reg);
            s1_vzc_reg <= 52'(s0_vz_reg) * 52'(s0_c_reg);
            s1_rxc_reg <= 51'(dir_x_reg) * 51'(s0_c_reg);
            s1_rzs_reg <= 51'(dir_z_reg) * 51'(s0_s_reg);
            s1_rxs_reg <= 51'(dir_x_reg) * 51'(s0_s_reg);
            s1_rzc_reg <= 51'(dir_z_reg) * 51'(s0_c_reg);
            s1_vy_reg  <= s0_vy_reg;
            s1_kind_reg <= s0_kind_reg;
            s1_w_reg  <= s0_w_reg;
            s1_p2_reg <= s0_p2_reg;
            s1_p3_reg <= s0_p3_reg;
        end
    end

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)       return 32'sh7FFFFFFF;
        else if (v < -64'sd2147483648) return 32'sh80000000;
        else                           return 32'(v);
    endfunction

    function automatic logic signed [63:0] rnd(input logic signed [63:0] v);
        logic signed [63:0] a;
        a = v + (64'sd1 <<< (rrpl_pkg::FracBits - 1));
        return a >>> rrpl_pkg::FracBits;
    endfunction

    // s2: rotate sums, round, saturate
    side_t              s2_reg;
    logic signed [31:0] s2_p3_reg;
    logic [1:0]         s2_kind_reg;
    always_ff @(posedge clk)
    begin
        if (advance) begin
            s2_reg.lox <= sat32(rnd(64'(s1_vxc_reg) - 64'(s1_vzs_reg)));
            s2_reg.loz <= sat32(rnd(64'(s1_vxs_reg) + 64'(s1_vzc_reg)));
            s2_reg.loy <= sat32(64'(s1_vy_reg));
            s2_reg.dx  <= sat32(rnd(64'(s1_rxc_reg) - 64'(s1_rzs_reg)));
            s2_reg.dz  <= sat32(rnd(64'(s1_rxs_reg) + 64'(s1_rzc_reg)));
            s2_reg.dy  <= dir_y_reg;
            s2_reg.w   <= s1_w_reg;
            s2_reg.hd  <= s1_p2_reg;
            s2_reg.shelf <= (s1_kind_reg == rrpl_pkg::KIND_SHELF);
            s2_reg.ok  <= 1'b0;
            s2_p3_reg  <= s1_p3_reg;
            s2_kind_reg <= s1_kind_reg;
        end
    end

    // s3: numerator, denominator, parallel test
    side_t                      s3_reg;
    side_t                      s3_next;
    logic signed [N-1:0]        s3_num_reg;
    logic signed [34:0]         s3_den_reg;
    logic signed [31:0]         s3_tdepth_reg;  // table depth when table
    logic signed [31:0]         den;
    logic signed [32:0]         aden;
    logic signed [34:0]         num2;
    always_comb
    begin
        den  = s2_reg.shelf ? s2_reg.dz : s2_reg.dy;
        aden = den[31] ? -33'(den) : 33'(den);
        num2 = s2_reg.shelf ? 35'(s2_p3_reg) - 35'(s2_reg.loz) * 35'sd2
                            : 35'(s2_p3_reg) * 35'sd2 - 35'(s2_reg.loy) * 35'sd2;
        s3_next    = s2_reg;
        s3_next.ok = (s2_kind_reg == rrpl_pkg::KIND_TABLE || s2_kind_reg == rrpl_pkg::KIND_SHELF)
                     && den != 0 && aden >= 33'(eps_reg);
    end
    always_ff @(posedge clk)
    begin
        if (advance) begin
            s3_reg     <= s3_next;
            s3_num_reg <= N'(num2) <<< rrpl_pkg::FracBits;
            s3_den_reg <= 35'(den) * 35'sd2;
            // shelf depth lives in p3; table depth in hd
            s3_tdepth_reg <= s2_reg.shelf ? s2_p3_reg : s2_reg.hd;
        end
    end

    logic signed [N-1:0] quot;
    rrpl_div u_div (
        .clk     (clk),
        .advance (advance),
        .num     (s3_num_reg),
        .den     (s3_den_reg),
        .quot    (quot)
    );

    // sideband delay line alongside the divider
    side_t              dl_reg [N+1];
    logic signed [31:0] dd_reg [N+1];
    always_ff @(posedge clk)
    begin
        if (advance) begin
            dl_reg[0] <= s3_reg;
            dd_reg[0] <= s3_tdepth_reg;
            for (int i = 0; i < N; i++) begin
                dl_reg[i+1] <= dl_reg[i];
                dd_reg[i+1] <= dd_reg[i];
            end
        end
    end
    side_t              sq;
    logic signed [31:0] sqd;
    assign sq  = dl_reg[N];
    assign sqd = dd_reg[N];

    // s4: saturate t, products
    side_t              s4_reg;
    logic signed [31:0] s4_d_reg;
    logic               s4_tpos_reg;
    logic signed [63:0] s4_mx_reg, s4_my_reg, s4_mz_reg;
    logic signed [31:0] t_sat;
    assign t_sat = sat32(quot > (N)'(64'sd2147483647) ? 64'sd2147483647 :
                         quot < -(N)'(64'sd2147483648) ? -64'sd2147483648 : 64'(quot));
    always_ff @(posedge clk)
    begin
        if (advance) begin
            s4_reg      <= sq;
            s4_d_reg    <= sqd;
            s4_tpos_reg <= t_sat > 0;
            s4_mx_reg   <= 64'(sq.dx) * 64'(t_sat);
            s4_my_reg   <= 64'(sq.dy) * 64'(t_sat);
            s4_mz_reg   <= 64'(sq.dz) * 64'(t_sat);
        end
    end

    // s5: hit point and rectangle test, full precision (|d*t| reaches 2^46)
    logic signed [48:0] hx, hy, hz;
    logic               in_rect;
    always_comb
    begin
        hx = 49'(s4_reg.lox) + 49'(rnd(s4_mx_reg));
        hy = 49'(s4_reg.loy) + 49'(rnd(s4_my_reg));
        hz = 49'(s4_reg.loz) + 49'(rnd(s4_mz_reg));
        if (s4_reg.shelf)
            in_rect = (hx * 49'sd2 >= -49'(s4_reg.w)) && (hx * 49'sd2 <= 49'(s4_reg.w))
                      && (hy >= 49'sd0) && (hy <= 49'(s4_reg.hd));
        else
            in_rect = (hx * 49'sd2 >= -49'(s4_reg.w)) && (hx * 49'sd2 <= 49'(s4_reg.w))
                      && (hz * 49'sd2 >= -49'(s4_d_reg)) && (hz * 49'sd2 <= 49'(s4_d_reg));
    end

    logic               hit;
    assign hit = s4_reg.ok && s4_tpos_reg && in_rect;

    rrpl_pkg::out_beat_t res_reg;
    always_ff @(posedge clk)
    begin
        if (advance) begin
            res_reg.hit     <= hit;
            res_reg.local_x <= hit ? sat32(64'(hx)) : '0;
            res_reg.local_y <= hit ? sat32(64'(hy)) : '0;
            res_reg.local_z <= hit ? sat32(64'(hz)) : '0;
        end
    end

    assign out_valid = vld_reg[Pipe-1];
    assign out_data  = res_reg;

    // a stalled result must stay put
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed under stall");
    // miss results carry zero coordinates
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.hit |-> out_data.local_x == 0 && out_data.local_y == 0
                                      && out_data.local_z == 0)
        else $error("miss with nonzero point");
    // input accepted whenever the output slot frees
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("pipe stalled with empty output");
endmodule

/* dv/rrpl_checker.sv */
`timescale 1ns / 1ps
module rrpl_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  rrpl_pkg::in_beat_t  in_data,
    input  logic                out_valid,
    input  logic                out_ready,
    input  rrpl_pkg::out_beat_t out_data,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    output int                  errors,
    output int                  pending
);
    localparam int Frac = rrpl_pkg::FracBits;

    logic signed [31:0]  org_x, org_y, org_z, dir_x, dir_y, dir_z;
    logic [16:0]         eps;
    rrpl_pkg::out_beat_t hit_q[$];
    longint              sine_tab[256];

    function automatic longint qsin(longint u);
        longint unsigned x, term;
        longint sum;
        x = (longint'(u) * 64'd3373259426) >> 15;
        term = x;
        sum = x;
        for (int n = 1; n <= 6; n++)
        begin
            term = (((term * x) >> 30) * x) >> 30;
            term = term / ((2 * n) * (2 * n + 1));
            if (n % 2 == 1) sum -= longint'(term);
            else sum += longint'(term);
        end
        if (sum < 0) sum = 0;
        if (sum > (64'sd1 <<< 30)) sum = 64'sd1 <<< 30;
        return sum;
    endfunction

    initial
    begin
        longint phase, q, r, u, mag;
        for (int i = 0; i < 256; i++)
        begin
            phase = (i * 65536 / 256) & 16'hFFFF;
            q = (phase >> 14) & 3;
            r = phase & 16'h3FFF;
            u = (q & 1) ? 16384 - r : r;
            mag = (qsin(u) + (64'sd1 <<< (29 - Frac))) >>> (30 - Frac);
            sine_tab[i] = (q & 2) ? -mag : mag;
        end
    end

    function automatic longint lookup_sin(logic [15:0] ang);
        return sine_tab[ang >> 8];
    endfunction

    function automatic longint round_q(longint v);
        return (v + (64'sd1 <<< (Frac - 1))) >>> Frac;
    endfunction

    function automatic longint clip32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // expected hit test for one object against the current ray
    function automatic rrpl_pkg::out_beat_t pick_object(rrpl_pkg::in_beat_t b);
        rrpl_pkg::out_beat_t res;
        longint s, c, vx, vy, vz, lox, loy, loz, dx, dy, dz;
        longint w, d, h, den, aden, num2, t, hx, hy, hz;
        logic [15:0] ca;
        bit ok;
        res = '0;
        if (b.kind != rrpl_pkg::KIND_TABLE && b.kind != rrpl_pkg::KIND_SHELF) return res;
        ca = b.yaw_angle + 16'd16384;
        s = lookup_sin(b.yaw_angle);
        c = lookup_sin(ca);
        vx = longint'(org_x) - longint'(b.pos_x);
        vy = longint'(org_y) - longint'(b.pos_y);
        vz = longint'(org_z) - longint'(b.pos_z);
        lox = clip32(round_q(vx * c - vz * s));
        loy = clip32(vy);
        loz = clip32(round_q(vx * s + vz * c));
        dx = clip32(round_q(longint'(dir_x) * c - longint'(dir_z) * s));
        dy = dir_y;
        dz = clip32(round_q(longint'(dir_x) * s + longint'(dir_z) * c));
        if (b.kind == rrpl_pkg::KIND_TABLE)
        begin
            w = b.param_count > 0 ? longint'(b.param_first) : longint'(rrpl_pkg::TABLE_W);
            d = b.param_count > 1 ? longint'(b.param_second) : longint'(rrpl_pkg::TABLE_D);
            h = b.param_count > 2 ? longint'(b.param_third) : longint'(rrpl_pkg::TABLE_H);
            den = dy;
            num2 = 2 * h - 2 * loy;
        end
        else
        begin
            w = b.param_count > 0 ? longint'(b.param_first) : longint'(rrpl_pkg::SHELF_W);
            h = b.param_count > 1 ? longint'(b.param_second) : longint'(rrpl_pkg::SHELF_H);
            d = b.param_count > 2 ? longint'(b.param_third) : longint'(rrpl_pkg::SHELF_D);
            den = dz;
            num2 = d - 2 * loz;
        end
        aden = den < 0 ? -den : den;
        if (den == 0 || aden < longint'(eps)) return res;
        t = clip32((num2 * 65536) / (2 * den));   // truncates toward zero
        if (t <= 0) return res;
        hx = lox + round_q(dx * t);
        hy = loy + round_q(dy * t);
        hz = loz + round_q(dz * t);
        if (b.kind == rrpl_pkg::KIND_TABLE)
            ok = 2 * hx >= -w && 2 * hx <= w && 2 * hz >= -d && 2 * hz <= d;
        else
            ok = 2 * hx >= -w && 2 * hx <= w && hy >= 0 && hy <= h;
        if (!ok) return res;
        res.hit = 1'b1;
        res.local_x = 32'(clip32(hx));
        res.local_y = 32'(clip32(hy));
        res.local_z = 32'(clip32(hz));
        return res;
    endfunction

    assign pending = hit_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        rrpl_pkg::out_beat_t e;
        if (!rst_n)
        begin
            org_x <= '0; org_y <= '0; org_z <= '0;
            dir_x <= '0; dir_y <= '0; dir_z <= '0;
            eps <= 17'd1;
            errors <= 0;
            hit_q.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    rrpl_pkg::REG_ORG_X: org_x <= cfg_data;
                    rrpl_pkg::REG_ORG_Y: org_y <= cfg_data;
                    rrpl_pkg::REG_ORG_Z: org_z <= cfg_data;
                    rrpl_pkg::REG_DIR_X: dir_x <= cfg_data;
                    rrpl_pkg::REG_DIR_Y: dir_y <= cfg_data;
                    rrpl_pkg::REG_DIR_Z: dir_z <= cfg_data;
                    rrpl_pkg::REG_EPS:   eps <= cfg_data[16:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                hit_q.push_back(pick_object(in_data));
            if (out_valid && out_ready)
            begin
                if (hit_q.size() == 0)
                begin
                    $error("result beat with nothing expected");
                    errors <= errors + 1;
                end
                else
                begin
                    e = hit_q.pop_front();
                    if (out_data.hit !== e.hit)
                    begin
                        $error("hit: expected %0d actual %0d", e.hit, out_data.hit);
                        errors <= errors + 1;
                    end
                    else if (out_data.local_x !== e.local_x)
                    begin
                        $error("local_x: expected %0d actual %0d", e.local_x, out_data.local_x);
                        errors <= errors + 1;
                    end
                    else if (out_data.local_y !== e.local_y)
                    begin
                        $error("local_y: expected %0d actual %0d", e.local_y, out_data.local_y);
                        errors <= errors + 1;
                    end
                    else if (out_data.local_z !== e.local_z)
                    begin
                        $error("local_z: expected %0d actual %0d", e.local_z, out_data.local_z);
                        errors <= errors + 1;
                    end
                end
            end
        end
    end
endmodule

/* dv/tb_ray_rect_pick_local.sv */
`timescale 1ns / 1ps
module tb_ray_rect_pick_local;

    localparam int Latency = 73;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    rrpl_pkg::in_beat_t  in_data = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    rrpl_pkg::out_beat_t out_data;
    logic                cfg_we = 1'b0;
    logic [2:0]          cfg_index = '0;
    logic [31:0]         cfg_data = '0;
    int                  errors;
    int                  pending;

    // receiver: 0 = random stalls, 1 = always ready, 2 = long hold-off
    int          rx_mode = 0;
    bit          quiet = 1'b0;     // no idling in the last part

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    ray_rect_pick_local u_top (.*);

    rrpl_checker u_chk (.*);

    initial
    begin
        #60ms;
        $display("Simulation FAILED");
        $finish;
    end

    // receiver: bursts of stall, and one long hold-off on request
    initial
    begin
        int n;
        forever
        begin
            @(negedge clk);
            if (rx_mode == 2)
            begin
                out_ready <= 1'b0;
                repeat (200) @(negedge clk);
                rx_mode = 1;
            end
            else if (!quiet && rx_mode == 0 && $urandom_range(0, 5) == 0)
            begin
                n = $urandom_range(1, 11);
                out_ready <= 1'b0;
                repeat (n - 1) @(negedge clk);
            end
            else
                out_ready <= 1'b1;
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // wait for the pipe to empty so registers can change safely
    task automatic drain();
        while (pending != 0) @(negedge clk);
        repeat (Latency + 4) @(negedge clk);
    endtask

    // offer one object beat; called at a falling edge, returns after acceptance
    task automatic send_object(rrpl_pkg::in_beat_t b);
        int n;
        if (!quiet && $urandom_range(0, 7) == 0)
        begin
            n = $urandom_range(1, 11);
            in_valid <= 1'b0;
            repeat (n) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= b;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic idle_input();
        in_valid <= 1'b0;
    endtask

    function automatic logic [31:0] rand_coord(int span);
        return $signed($urandom_range(0, 2 * span)) - span;
    endfunction

    // object mostly near the ray so hits occur; some fully random
    function automatic rrpl_pkg::in_beat_t make_object();
        rrpl_pkg::in_beat_t b;
        b.kind = $urandom_range(0, 9) == 0 ? 2'($urandom_range(2, 3)) : 2'($urandom_range(0, 1));
        b.param_count = 2'($urandom);
        b.yaw_angle = 16'($urandom);
        if ($urandom_range(0, 9) == 0)
        begin
            b.param_first = $urandom;
            b.param_second = $urandom;
            b.param_third = $urandom;
            b.pos_x = $urandom;
            b.pos_y = $urandom;
            b.pos_z = $urandom;
        end
        else
        begin
            b.param_first = $urandom_range(0, 9) == 0 ? rand_coord(65536) : $urandom_range(0, 196608);
            b.param_second = $urandom_range(0, 196608);
            b.param_third = $urandom_range(0, 196608);
            b.pos_x = rand_coord(131072);
            b.pos_y = rand_coord(131072);
            b.pos_z = rand_coord(131072);
        end
        return b;
    endfunction

    task automatic set_ray(logic [31:0] ox, oy, oz, dx, dy, dz, logic [31:0] e);
        write_reg(rrpl_pkg::REG_ORG_X, ox);
        write_reg(rrpl_pkg::REG_ORG_Y, oy);
        write_reg(rrpl_pkg::REG_ORG_Z, oz);
        write_reg(rrpl_pkg::REG_DIR_X, dx);
        write_reg(rrpl_pkg::REG_DIR_Y, dy);
        write_reg(rrpl_pkg::REG_DIR_Z, dz);
        write_reg(rrpl_pkg::REG_EPS, e);
    endtask

    initial
    begin
        rrpl_pkg::in_beat_t b;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: ray from above looking down, then toward -z
        set_ray(32'sd0, 32'sd196608, 32'sd0, 32'sd0, -32'sd65536, 32'sd0, 32'd1);
        for (int k = 0; k < 4; k++)
        begin
            b = '0;
            b.kind = rrpl_pkg::KIND_TABLE;
            b.param_count = 2'(k);
            b.param_first = 32'sd131072;
            b.param_second = 32'sd131072;
            b.param_third = 32'sd32768;
            b.yaw_angle = 16'(k * 16384);
            send_object(b);
        end
        b = '0; b.kind = 2'd2; send_object(b);
        b.kind = 2'd3; send_object(b);
        b = '0; b.kind = rrpl_pkg::KIND_TABLE; b.param_count = 2'd3;
        b.param_first = -32'sd65536; send_object(b);               // empty rectangle
        b.param_first = 32'sd0; b.param_second = 32'sd0; send_object(b); // edge point
        b.param_first = 32'h7FFFFFFF; b.param_second = 32'h7FFFFFFF;
        b.param_third = 32'h80000000; send_object(b);
        b.pos_x = 32'h80000000; b.pos_y = 32'h7FFFFFFF; b.pos_z = 32'h80000000;
        b.yaw_angle = 16'hFFFF; send_object(b);
        b = '0; b.kind = rrpl_pkg::KIND_TABLE; b.param_count = 2'd3;
        b.param_third = 32'sd262144; send_object(b);               // plane behind, t <= 0
        b.kind = rrpl_pkg::KIND_SHELF; send_object(b);             // parallel to front plane
        idle_input();
        drain();

        set_ray(32'sd0, 32'sd65536, 32'sd196608, 32'sd0, 32'sd0, -32'sd65536, 32'd65536);
        for (int k = 0; k < 4; k++)
        begin
            b = '0;
            b.kind = rrpl_pkg::KIND_SHELF;
            b.param_count = 2'(k);
            b.param_first = 32'sd131072;
            b.param_second = 32'sd131072;
            b.param_third = 32'sd65536;
            send_object(b);
        end
        b.pos_y = 32'sd65536; send_object(b);                      // y = 0 edge
        b.yaw_angle = 16'd16384; send_object(b);                   // now parallel
        idle_input();
        drain();

        // random phases over several ray settings
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: set_ray(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                           32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'd0);
                1: set_ray(32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'd0);
                2: set_ray(32'h80000000, 32'h7FFFFFFF, 32'h80000000,
                           32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'd65536);
                default: set_ray(rand_coord(131072), rand_coord(262144), rand_coord(131072),
                                 rand_coord(65536), rand_coord(65536), rand_coord(65536),
                                 32'($urandom_range(0, 1000)));
            endcase
            if (ph == 7) quiet = 1'b1;
            for (int i = 0; i < (ph < 3 ? 60 : 230); i++)
            begin
                if (ph == 4 && i == 20) rx_mode = 2;     // stall the output, keep sending
                if (ph == 5 && i == 100)
                begin
                    idle_input();
                    while (pending != 0) @(negedge clk);
                end
                send_object(make_object());
            end
            idle_input();
            drain();
            rx_mode = 0;
        end

        repeat (Latency) @(negedge clk);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
